// ===== rtl/qbc_pkg.sv =====
// ----------------------------------------------------------------------------
// qbc_pkg: shared types and constants for the quad bimedian center block
// Field widths, datapath widths, sequencer op codes, FSM states, MAC command.
// ----------------------------------------------------------------------------
package qbc_pkg;

    localparam int C_W       = 16;          // corner coordinate
    localparam int M_W       = C_W + 1;     // doubled midpoint
    localparam int DIF_W     = M_W + 1;     // midpoint difference
    localparam int D_W       = 38;          // determinant, room for abs
    localparam int PP_W      = 35;          // pre / post cross terms
    localparam int NUM_W     = 54;          // crossing numerators
    localparam int ACC_W     = 56;          // MAC accumulator
    localparam int A_W       = D_W;         // MAC parallel operand
    localparam int B_W       = DIF_W;       // MAC serial operand
    localparam int Q_W       = 24;          // Q16.8 quotient magnitude
    localparam int FRAC_SH   = 7;           // num*128/d
    localparam int R_W       = NUM_W + FRAC_SH;
    localparam int OUT_W     = 24;
    localparam int MAC_CNT_W = $clog2(B_W);
    localparam int DIV_CNT_W = $clog2(Q_W);

    typedef enum logic [4:0] {
        OP_DET0,
        OP_DET1,
        OP_PRE0,
        OP_PRE1,
        OP_POST0,
        OP_POST1,
        OP_NX0,
        OP_NX1,
        OP_NY0,
        OP_NY1,
        OP_SX1,
        OP_SX2,
        OP_SX3,
        OP_SX4,
        OP_SY1,
        OP_SY2,
        OP_SY3,
        OP_SY4
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC_GO,
        ST_MAC_WAIT,
        ST_FIX,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT
    } state_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic sub;
    } mac_cmd_t;

endpackage

// ===== rtl/quad_bimedian_center_top.sv =====
// ----------------------------------------------------------------------------
// quad_bimedian_center_top: quadrilateral center from crossing bimedians
// Intersects the two bimedians of four corners, checks the crossing lies on
// both segments, and reports it in signed Q16.8 (or the stored center).
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake              payload
//  -------   ---   ---------              -------
//  command   in    start & !busy          corner0_x .. corner3_y (s16 each)
//  result    out   done, one-cycle pulse  center_x, center_y (s24), found
//
//  An item's run time is set by the shared bit-serial MAC, which forms 18
//  products from an 18-bit serial operand one after another, and then by two
//  serial divisions of 24 quotient bits each; a zero determinant ends the
//  item after the two determinant products.
//  busy is high from accept until the cycle of the done pulse; start is
//  ignored while busy. done cannot be stalled: the receiver must take the
//  result in the strobe cycle; the block itself does not enforce this. Reset
//  clears control and the stored center to zero.
module quad_bimedian_center_top
    import qbc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [C_W-1:0]   corner0_x,
    input  logic signed [C_W-1:0]   corner0_y,
    input  logic signed [C_W-1:0]   corner1_x,
    input  logic signed [C_W-1:0]   corner1_y,
    input  logic signed [C_W-1:0]   corner2_x,
    input  logic signed [C_W-1:0]   corner2_y,
    input  logic signed [C_W-1:0]   corner3_x,
    input  logic signed [C_W-1:0]   corner3_y,
    output logic                    done,
    output logic signed [OUT_W-1:0] center_x,
    output logic signed [OUT_W-1:0] center_y,
    output logic                    found
);

    // control
    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   ok_reg, ok_next;
    logic   done_reg, done_next;
    logic   found_reg, found_next;

    // doubled midpoints: 1 = mid(c0,c1), 2 = mid(c3,c2), 3 = mid(c0,c3),
    // 4 = mid(c1,c2)
    logic signed [M_W-1:0] x1_reg, x1_next, y1_reg, y1_next;
    logic signed [M_W-1:0] x2_reg, x2_next, y2_reg, y2_next;
    logic signed [M_W-1:0] x3_reg, x3_next, y3_reg, y3_next;
    logic signed [M_W-1:0] x4_reg, x4_next, y4_reg, y4_next;
    logic signed [DIF_W-1:0] dxa, dya, dxb, dyb;

    // intermediate terms
    logic signed [D_W-1:0]   d_reg, d_next;
    logic signed [PP_W-1:0]  pre_reg, pre_next;
    logic signed [PP_W-1:0]  post_reg, post_next;
    logic signed [NUM_W-1:0] nx_reg, nx_next;
    logic signed [NUM_W-1:0] ny_reg, ny_next;
    logic signed [ACC_W-1:0] p_reg, p_next;
    logic signed [OUT_W-1:0] qx_reg, qx_next;

    // result and stored center
    logic signed [OUT_W-1:0] cx_reg, cx_next;
    logic signed [OUT_W-1:0] cy_reg, cy_next;
    logic signed [OUT_W-1:0] lx_reg, lx_next;
    logic signed [OUT_W-1:0] ly_reg, ly_next;

    // MAC
    mac_cmd_t                mac_cmd;
    logic signed [A_W-1:0]   mac_a;
    logic signed [B_W-1:0]   mac_b;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_done;
    logic                    op_clear;
    logic                    op_sub;

    // divider
    logic                    div_start;
    logic [R_W-1:0]          div_num;
    logic [Q_W-1:0]          div_quo;
    logic                    div_done;
    logic [NUM_W-1:0]        nx_mag, ny_mag;
    logic signed [OUT_W-1:0] q_signed;

    // on-segment test
    logic signed [ACC_W-1:0] num_ext;
    logic                    span_ok;

    assign dxa = DIF_W'(x1_reg) - DIF_W'(x2_reg);
    assign dya = DIF_W'(y1_reg) - DIF_W'(y2_reg);
    assign dxb = DIF_W'(x3_reg) - DIF_W'(x4_reg);
    assign dyb = DIF_W'(y3_reg) - DIF_W'(y4_reg);

    // operand select per sequencer op; odd cross-term ops subtract
    always_comb
    begin
        op_clear = 1'b1;
        op_sub   = 1'b0;
        mac_a    = d_reg;
        mac_b    = '0;
        unique case (op_reg)
            OP_DET0:
            begin
                mac_a = {{(A_W - DIF_W){dxa[DIF_W-1]}}, dxa};
                mac_b = dyb;
            end
            OP_DET1:
            begin
                mac_a    = {{(A_W - DIF_W){dya[DIF_W-1]}}, dya};
                mac_b    = dxb;
                op_clear = 1'b0;
                op_sub   = 1'b1;
            end
            OP_PRE0:
            begin
                mac_a = {{(A_W - M_W){x1_reg[M_W-1]}}, x1_reg};
                mac_b = {{(B_W - M_W){y2_reg[M_W-1]}}, y2_reg};
            end
            OP_PRE1:
            begin
                mac_a    = {{(A_W - M_W){y1_reg[M_W-1]}}, y1_reg};
                mac_b    = {{(B_W - M_W){x2_reg[M_W-1]}}, x2_reg};
                op_clear = 1'b0;
                op_sub   = 1'b1;
            end
            OP_POST0:
            begin
                mac_a = {{(A_W - M_W){x3_reg[M_W-1]}}, x3_reg};
                mac_b = {{(B_W - M_W){y4_reg[M_W-1]}}, y4_reg};
            end
            OP_POST1:
            begin
                mac_a    = {{(A_W - M_W){y3_reg[M_W-1]}}, y3_reg};
                mac_b    = {{(B_W - M_W){x4_reg[M_W-1]}}, x4_reg};
                op_clear = 1'b0;
                op_sub   = 1'b1;
            end
            OP_NX0:
            begin
                mac_a = {{(A_W - PP_W){pre_reg[PP_W-1]}}, pre_reg};
                mac_b = dxb;
            end
            OP_NX1:
            begin
                mac_a    = {{(A_W - PP_W){post_reg[PP_W-1]}}, post_reg};
                mac_b    = dxa;
                op_clear = 1'b0;
                op_sub   = 1'b1;
            end
            OP_NY0:
            begin
                mac_a = {{(A_W - PP_W){pre_reg[PP_W-1]}}, pre_reg};
                mac_b = dyb;
            end
            OP_NY1:
            begin
                mac_a    = {{(A_W - PP_W){post_reg[PP_W-1]}}, post_reg};
                mac_b    = dya;
                op_clear = 1'b0;
                op_sub   = 1'b1;
            end
            OP_SX1: mac_b = {{(B_W - M_W){x1_reg[M_W-1]}}, x1_reg};
            OP_SX2: mac_b = {{(B_W - M_W){x2_reg[M_W-1]}}, x2_reg};
            OP_SX3: mac_b = {{(B_W - M_W){x3_reg[M_W-1]}}, x3_reg};
            OP_SX4: mac_b = {{(B_W - M_W){x4_reg[M_W-1]}}, x4_reg};
            OP_SY1: mac_b = {{(B_W - M_W){y1_reg[M_W-1]}}, y1_reg};
            OP_SY2: mac_b = {{(B_W - M_W){y2_reg[M_W-1]}}, y2_reg};
            OP_SY3: mac_b = {{(B_W - M_W){y3_reg[M_W-1]}}, y3_reg};
            OP_SY4: mac_b = {{(B_W - M_W){y4_reg[M_W-1]}}, y4_reg};
            default: mac_b = '0;
        endcase
    end

    // d > 0 here, so min(a,b)*d = min(a*d, b*d): test num between the two
    always_comb
    begin
        if (op_reg == OP_SX2 || op_reg == OP_SX4)
        begin
            num_ext = {{(ACC_W - NUM_W){nx_reg[NUM_W-1]}}, nx_reg};
        end
        else
        begin
            num_ext = {{(ACC_W - NUM_W){ny_reg[NUM_W-1]}}, ny_reg};
        end
        span_ok = (num_ext >= p_reg && num_ext <= mac_acc) ||
                  (num_ext >= mac_acc && num_ext <= p_reg);
    end

    // divider works on magnitudes; sign restored on the quotient
    always_comb
    begin
        nx_mag = nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
        ny_mag = ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
        if (state_reg == ST_DIVX_GO)
        begin
            div_num = {nx_mag, {FRAC_SH{1'b0}}};
        end
        else
        begin
            div_num = {ny_mag, {FRAC_SH{1'b0}}};
        end
        if (state_reg == ST_DIVX_WAIT ? nx_reg[NUM_W-1] : ny_reg[NUM_W-1])
        begin
            q_signed = -$signed(div_quo);
        end
        else
        begin
            q_signed = $signed(div_quo);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ok_next    = ok_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        x1_next    = x1_reg;
        y1_next    = y1_reg;
        x2_next    = x2_reg;
        y2_next    = y2_reg;
        x3_next    = x3_reg;
        y3_next    = y3_reg;
        x4_next    = x4_reg;
        y4_next    = y4_reg;
        d_next     = d_reg;
        pre_next   = pre_reg;
        post_next  = post_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        p_next     = p_reg;
        qx_next    = qx_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        lx_next    = lx_reg;
        ly_next    = ly_reg;
        mac_cmd.start = 1'b0;
        mac_cmd.clear = op_clear;
        mac_cmd.sub   = op_sub;
        div_start  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    x1_next    = M_W'(corner0_x) + M_W'(corner1_x);
                    y1_next    = M_W'(corner0_y) + M_W'(corner1_y);
                    x2_next    = M_W'(corner3_x) + M_W'(corner2_x);
                    y2_next    = M_W'(corner3_y) + M_W'(corner2_y);
                    x3_next    = M_W'(corner0_x) + M_W'(corner3_x);
                    y3_next    = M_W'(corner0_y) + M_W'(corner3_y);
                    x4_next    = M_W'(corner1_x) + M_W'(corner2_x);
                    y4_next    = M_W'(corner1_y) + M_W'(corner2_y);
                    op_next    = OP_DET0;
                    state_next = ST_MAC_GO;
                end
            end
            ST_MAC_GO:
            begin
                mac_cmd.start = 1'b1;
                state_next    = ST_MAC_WAIT;
            end
            ST_MAC_WAIT:
            begin
                if (mac_done)
                begin
                    op_next    = op_t'(op_reg + 5'd1);
                    state_next = ST_MAC_GO;
                    case (op_reg)
                        OP_DET1:
                        begin
                            d_next = mac_acc[D_W-1:0];
                            if (mac_acc == '0)
                            begin
                                // parallel or degenerate bimedians
                                cx_next    = lx_reg;
                                cy_next    = ly_reg;
                                found_next = 1'b0;
                                done_next  = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        OP_PRE1:  pre_next  = mac_acc[PP_W-1:0];
                        OP_POST1: post_next = mac_acc[PP_W-1:0];
                        OP_NX1:   nx_next   = mac_acc[NUM_W-1:0];
                        OP_NY1:
                        begin
                            ny_next    = mac_acc[NUM_W-1:0];
                            state_next = ST_FIX;
                        end
                        OP_SX1, OP_SX3, OP_SY1, OP_SY3: p_next = mac_acc;
                        OP_SX2, OP_SX4, OP_SY2: ok_next = ok_reg & span_ok;
                        OP_SY4:
                        begin
                            if (ok_reg && span_ok)
                            begin
                                state_next = ST_DIVX_GO;
                            end
                            else
                            begin
                                // crossing off a segment
                                cx_next    = lx_reg;
                                cy_next    = ly_reg;
                                found_next = 1'b0;
                                done_next  = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FIX:
            begin
                // make d positive, numerators follow
                if (d_reg[D_W-1])
                begin
                    d_next  = -d_reg;
                    nx_next = -nx_reg;
                    ny_next = -ny_reg;
                end
                ok_next    = 1'b1;
                op_next    = OP_SX1;
                state_next = ST_MAC_GO;
            end
            ST_DIVX_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVX_WAIT;
            end
            ST_DIVX_WAIT:
            begin
                if (div_done)
                begin
                    qx_next    = q_signed;
                    state_next = ST_DIVY_GO;
                end
            end
            ST_DIVY_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVY_WAIT;
            end
            ST_DIVY_WAIT:
            begin
                if (div_done)
                begin
                    cx_next    = qx_reg;
                    cy_next    = q_signed;
                    lx_next    = qx_reg;
                    ly_next    = q_signed;
                    found_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_DET0;
            ok_reg    <= 1'b0;
            done_reg  <= 1'b0;
            lx_reg    <= '0;
            ly_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ok_reg    <= ok_next;
            done_reg  <= done_next;
            lx_reg    <= lx_next;
            ly_reg    <= ly_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        x2_reg    <= x2_next;
        y2_reg    <= y2_next;
        x3_reg    <= x3_next;
        y3_reg    <= y3_next;
        x4_reg    <= x4_next;
        y4_reg    <= y4_next;
        d_reg     <= d_next;
        pre_reg   <= pre_next;
        post_reg  <= post_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        p_reg     <= p_next;
        qx_reg    <= qx_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        found_reg <= found_next;
    end

    qbc_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    qbc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (d_reg),
        .quo   (div_quo),
        .done  (div_done)
    );

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign center_x = cx_reg;
    assign center_y = cy_reg;
    assign found    = found_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a result strobe is never followed by another one right away
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe lasted more than one cycle");

    // a miss repeats the stored center
    a_miss_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (center_x == lx_reg && center_y == ly_reg))
        else $error("miss result differs from stored center");

    // accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVX_WAIT || state_reg == ST_DIVY_WAIT))
        else $error("divider done outside a divide wait state");

endmodule

// ===== rtl/qbc_mac.sv =====
// ----------------------------------------------------------------------------
// qbc_mac: bit-serial signed multiply-accumulate
// acc (+/-)= a * b, one bit of b per cycle, two's complement sign bit last.
// ----------------------------------------------------------------------------
module qbc_mac
    import qbc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_cmd_t                cmd,
    input  logic signed [A_W-1:0]   a,
    input  logic signed [B_W-1:0]   b,
    output logic signed [ACC_W-1:0] acc,
    output logic                    done
);

    logic                    busy_reg;
    logic                    busy_next;
    logic                    done_reg;
    logic                    done_next;
    logic [MAC_CNT_W-1:0]    cnt_reg;
    logic [MAC_CNT_W-1:0]    cnt_next;
    logic                    sub_reg;
    logic [ACC_W-1:0]        a_sh_reg;
    logic [B_W-1:0]          b_sh_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic                    last;
    logic                    neg;
    logic [ACC_W-1:0]        addend;

    // sign bit of b carries negative weight
    always_comb
    begin
        last = (cnt_reg == MAC_CNT_W'(B_W - 1));
        neg  = sub_reg ^ last;
        if (!b_sh_reg[0])
        begin
            addend = '0;
        end
        else if (neg)
        begin
            addend = ~a_sh_reg + ACC_W'(1);
        end
        else
        begin
            addend = a_sh_reg;
        end
        acc_next  = acc_reg + $signed(addend);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + MAC_CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_sh_reg <= {{(ACC_W - A_W){a[A_W-1]}}, a};
            b_sh_reg <= b;
            sub_reg  <= cmd.sub;
            if (cmd.clear)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            a_sh_reg <= {a_sh_reg[ACC_W-2:0], 1'b0};
            b_sh_reg <= {1'b0, b_sh_reg[B_W-1:1]};
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ===== rtl/qbc_div.sv =====
// ----------------------------------------------------------------------------
// qbc_div: restoring divider, one quotient bit per cycle
// Unsigned num / den with the quotient known to fit Q_W bits.
// ----------------------------------------------------------------------------
module qbc_div
    import qbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [R_W-1:0]   num,
    input  logic [D_W-1:0]   den,
    output logic [Q_W-1:0]   quo,
    output logic             done
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [R_W-1:0]       rem_reg;
    logic [R_W-1:0]       dsh_reg;
    logic [Q_W-1:0]       q_reg;
    logic                 ge;

    always_comb
    begin
        ge        = (rem_reg >= dsh_reg);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(Q_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // divisor starts aligned to the top quotient bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= R_W'({den, {(Q_W - 1){1'b0}}});
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= {1'b0, dsh_reg[R_W-1:1]};
            q_reg   <= {q_reg[Q_W-2:0], ge};
        end
    end

    assign quo  = q_reg;
    assign done = done_reg;

endmodule
